[sv/slt_pkg.sv]
package slt_pkg;

    // Line counter width, fixed by the line_number field
    localparam int LINE_W = 9;

    // Default frame geometry
    localparam int LINES_PER_FRAME_DEF = 263;
    localparam int VISIBLE_LINES_DEF   = 192;

    // Line on which the 3D frame render is kicked off at line start
    localparam logic [LINE_W-1:0] RENDER_LINE = 9'd215;

    // Software-writable bits of a status word
    localparam logic [15:0] WRITE_MASK = 16'hFFB8;

    // Status word bit positions
    localparam int ST_VBLANK     = 0;
    localparam int ST_HBLANK     = 1;
    localparam int ST_MATCH      = 2;
    localparam int ST_VBLANK_IE  = 3;
    localparam int ST_HBLANK_IE  = 4;
    localparam int ST_MATCH_IE   = 5;

    // irq vector bit positions
    localparam int IRQ_VBLANK = 0;
    localparam int IRQ_HBLANK = 1;
    localparam int IRQ_MATCH  = 2;

    // cpu1 DMA trigger bit positions
    localparam int DMA_VBLANK = 0;
    localparam int DMA_HBLANK = 1;
    localparam int DMA_DISP   = 2;

    typedef enum logic [1:0] {
        OP_LINE_START = 2'd0,
        OP_LINE_END   = 2'd1,
        OP_WR_CPU0    = 2'd2,
        OP_WR_CPU1    = 2'd3
    } slt_op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] write_data;
    } slt_cmd_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [15:0]       status_cpu0;
        logic [15:0]       status_cpu1;
        logic [2:0]        irq_cpu0;
        logic [2:0]        irq_cpu1;
        logic [2:0]        dma_cpu1;
        logic              dma_cpu0_vblank;
        logic              draw_visible_line;
        logic              render_frame_3d;
    } slt_rsp_t;

    // Target line: bits 15:8 are target[7:0], bit 7 is target[8]
    function automatic logic [LINE_W-1:0] target_line(input logic [15:0] w);
        target_line = {w[7], w[15:8]};
    endfunction

endpackage

[sv/slt_if.sv]
interface slt_cmd_if;
    import slt_pkg::*;

    logic     valid;
    logic     ready;
    slt_cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface slt_rsp_if;
    import slt_pkg::*;

    logic     valid;
    logic     ready;
    slt_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/slt_in_stage.sv]
module slt_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  slt_pkg::slt_cmd_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output slt_pkg::slt_cmd_t dn_data
);
    import slt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    slt_cmd_t data_reg;

    // Refill whenever the held transaction leaves or the stage is empty
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[sv/slt_status_core.sv]
module slt_status_core #(
    parameter int LINES_PER_FRAME = slt_pkg::LINES_PER_FRAME_DEF,
    parameter int VISIBLE_LINES   = slt_pkg::VISIBLE_LINES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  slt_pkg::slt_cmd_t cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output slt_pkg::slt_rsp_t rsp_data
);
    import slt_pkg::*;

    // 10-bit compare constants so VISIBLE_LINES + 2 never overflows
    localparam logic [LINE_W:0] VIS_C      = (LINE_W+1)'(VISIBLE_LINES);
    localparam logic [LINE_W:0] VIS_P2_C   = (LINE_W+1)'(VISIBLE_LINES + 2);
    localparam logic [LINE_W:0] LPF_C      = (LINE_W+1)'(LINES_PER_FRAME);
    localparam logic [LINE_W:0] LPF_M1_C   = (LINE_W+1)'(LINES_PER_FRAME - 1);

    logic [LINE_W-1:0] line_counter_reg;
    logic [LINE_W-1:0] line_counter_next;
    logic [15:0]       status0_reg;
    logic [15:0]       status0_next;
    logic [15:0]       status1_reg;
    logic [15:0]       status1_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    slt_rsp_t          out_data_reg;
    slt_rsp_t          out_data_next;

    logic              advance;
    logic [LINE_W-1:0] line_inc;
    logic [LINE_W:0]   line_ext;
    logic [LINE_W:0]   inc_ext;

    assign cmd_ready = !out_valid_reg || rsp_ready;
    assign advance   = cmd_valid && cmd_ready;

    assign line_inc = line_counter_reg + 1'b1;
    assign line_ext = {1'b0, line_counter_reg};
    assign inc_ext  = {1'b0, line_inc};

    always_comb
    begin
        line_counter_next = line_counter_reg;
        status0_next      = status0_reg;
        status1_next      = status1_reg;
        out_data_next     = '0;

        case (slt_op_t'(cmd_data.opcode))
            OP_LINE_START:
            begin
                status0_next[ST_HBLANK] = 1'b1;
                status1_next[ST_HBLANK] = 1'b1;
                out_data_next.irq_cpu0[IRQ_HBLANK] = status0_reg[ST_HBLANK_IE];
                out_data_next.irq_cpu1[IRQ_HBLANK] = status1_reg[ST_HBLANK_IE];
                out_data_next.draw_visible_line    = line_ext < VIS_C;
                out_data_next.dma_cpu1[DMA_HBLANK] = line_ext < VIS_C;
                out_data_next.dma_cpu1[DMA_DISP]   = (line_ext > (LINE_W+1)'(1))
                                                     && (line_ext < VIS_P2_C);
                out_data_next.render_frame_3d      = line_counter_reg == RENDER_LINE;
            end
            OP_LINE_END:
            begin
                status0_next[ST_HBLANK] = 1'b0;
                status1_next[ST_HBLANK] = 1'b0;
                line_counter_next       = line_inc;
                if (inc_ext == VIS_C)
                begin
                    status0_next[ST_VBLANK] = 1'b1;
                    status1_next[ST_VBLANK] = 1'b1;
                    out_data_next.irq_cpu0[IRQ_VBLANK] = status0_reg[ST_VBLANK_IE];
                    out_data_next.irq_cpu1[IRQ_VBLANK] = status1_reg[ST_VBLANK_IE];
                    out_data_next.dma_cpu0_vblank      = 1'b1;
                    out_data_next.dma_cpu1[DMA_VBLANK] = 1'b1;
                end
                else if (inc_ext == LPF_M1_C)
                begin
                    status0_next[ST_VBLANK] = 1'b0;
                    status1_next[ST_VBLANK] = 1'b0;
                end
                else if (inc_ext >= LPF_C)
                begin
                    line_counter_next = '0;
                end
                // target-line compare against the new line
                status0_next[ST_MATCH] = target_line(status0_reg) == line_counter_next;
                status1_next[ST_MATCH] = target_line(status1_reg) == line_counter_next;
                out_data_next.irq_cpu0[IRQ_MATCH] = status0_next[ST_MATCH]
                                                    && status0_reg[ST_MATCH_IE];
                out_data_next.irq_cpu1[IRQ_MATCH] = status1_next[ST_MATCH]
                                                    && status1_reg[ST_MATCH_IE];
            end
            OP_WR_CPU0:
            begin
                status0_next = (status0_reg & ~WRITE_MASK) | (cmd_data.write_data & WRITE_MASK);
            end
            OP_WR_CPU1:
            begin
                status1_next = (status1_reg & ~WRITE_MASK) | (cmd_data.write_data & WRITE_MASK);
            end
            default:
            begin
                line_counter_next = line_counter_reg;
            end
        endcase

        out_data_next.line_number = line_counter_next;
        out_data_next.status_cpu0 = status0_next;
        out_data_next.status_cpu1 = status1_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_ready)
        begin
            out_valid_next = cmd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_counter_reg <= '0;
            status0_reg      <= '0;
            status1_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                line_counter_reg <= line_counter_next;
                status0_reg      <= status0_next;
                status1_reg      <= status1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

[sv/scanline_status_irq_timing_unit.sv]
// A cmd transaction passes the input register, then the result register, before it
// can leave as an rsp transaction.
// Throughput: 1 transaction per cycle while rsp is ready; the line counter and the
// two status words are updated between the two registers.
// Reset (rst_n, async, active low): line counter and both status words clear to 0,
// both pipeline stages empty.
module scanline_status_irq_timing_unit #(
    parameter int LINES_PER_FRAME = slt_pkg::LINES_PER_FRAME_DEF,
    parameter int VISIBLE_LINES   = slt_pkg::VISIBLE_LINES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    slt_cmd_if.sink   cmd,
    slt_rsp_if.source rsp
);
    import slt_pkg::*;

    // Input register -> status core. The core holds the frame state and the
    // result register; a full result register stalls the input stage only
    // when rsp is not taking the held transaction.
    logic     stg_valid;
    logic     stg_ready;
    slt_cmd_t stg_data;

    slt_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cmd.valid),
        .up_ready (cmd.ready),
        .up_data  (cmd.payload),
        .dn_valid (stg_valid),
        .dn_ready (stg_ready),
        .dn_data  (stg_data)
    );

    // Line start: hblank set, hblank irq/DMA, draw and display-start DMA, 3D render kick.
    // Line end: hblank clear, line advance with vblank entry/exit and wrap,
    // then the target-line compare for both status words.
    // Status writes touch only the writable bits; their side outputs are 0.
    slt_status_core #(
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .VISIBLE_LINES   (VISIBLE_LINES)
    ) u_status_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (stg_valid),
        .cmd_ready (stg_ready),
        .cmd_data  (stg_data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.payload)
    );

endmodule
